/* rtl/kvrp_pkg.sv */
`default_nettype none
package kvrp_pkg;

    localparam int unsigned CountW = 21;
    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
    localparam logic [CountW-1:0] CapReset = 21'd65536;
    localparam logic [4:0] MaxIdDigits = 5'd20;
    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW = 2;

    typedef enum logic [2:0] {
        TOK_KEY    = 3'd0,
        TOK_KEYEND = 3'd1,
        TOK_VAL    = 3'd2,
        TOK_LINE   = 3'd3,
        TOK_REC    = 3'd4
    } token_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_EQ    = 3'd1,
        ST_BAD_ID   = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_MISSING  = 3'd4,
        ST_OVER_CAP = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_REQ   = 2'd1,
        CLS_TYPE  = 2'd2
    } key_class_t;

    // What the front end decided for one accepted byte.
    typedef enum logic [2:0] {
        OP_CONTENT = 3'd0, // content byte or CR, optionally preceded by a released CR
        OP_LINE    = 3'd1, // newline ending a line (a result only if the line had content)
        OP_NOP     = 3'd2, // byte that gives no result (not produced by the front end)
        OP_TERM    = 3'd3, // record terminator
        OP_CAP     = 3'd4  // over-cap failure
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       cr_first;
        logic       emit_byte;
        logic [7:0] data;
    } cmd_t;

    localparam logic [7:0] ChNl = 8'h0A;
    localparam logic [7:0] ChCr = 8'h0D;
    localparam logic [7:0] ChEq = 8'h3D;
    localparam logic [7:0] ChZero = 8'h30;
    localparam logic [7:0] ChNine = 8'h39;

    function automatic logic [7:0] req_char(input logic [2:0] p);
        logic [7:0] c;
        begin
            unique case (p)
                3'd0: c = 8'h72;
                3'd1: c = 8'h65;
                3'd2: c = 8'h71;
                3'd3: c = 8'h5F;
                3'd4: c = 8'h69;
                3'd5: c = 8'h64;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    function automatic logic [7:0] type_char(input logic [2:0] p);
        logic [7:0] c;
        begin
            unique case (p)
                3'd0: c = 8'h74;
                3'd1: c = 8'h79;
                3'd2: c = 8'h70;
                3'd3: c = 8'h65;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/kvrp_front.sv */
`default_nettype none
module kvrp_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [20:0]                cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [7:0]                 in_byte,
    output logic                            cmd_valid,
    input  wire logic                       cmd_ready,
    output kvrp_pkg::cmd_t                  cmd
);

    logic [20:0] cap_reg;
    logic [20:0] count_reg, count_next;
    logic        prev_nl_reg, prev_nl_next;
    logic        held_cr_reg, held_cr_next;
    logic        stopped_reg, stopped_next;
    logic [20:0] cnt_inc;
    logic        fire;

    assign cfg_ready = 1'b1;
    // The stop flag only keeps bytes from becoming commands; the back end reports the status.
    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid && !stopped_reg;
    assign fire      = in_valid && in_ready;
    assign cnt_inc   = (count_reg != kvrp_pkg::CountMax) ? count_reg + 21'd1 : count_reg;

    always_comb begin
        count_next   = count_reg;
        prev_nl_next = prev_nl_reg;
        held_cr_next = held_cr_reg;
        stopped_next = stopped_reg;
        cmd.op        = kvrp_pkg::OP_NOP;
        cmd.cr_first  = 1'b0;
        cmd.emit_byte = 1'b0;
        cmd.data      = in_byte;
        if (in_byte == kvrp_pkg::ChNl && prev_nl_reg) begin
            cmd.op       = kvrp_pkg::OP_TERM;
            count_next   = '0;
            prev_nl_next = 1'b0;
            held_cr_next = 1'b0;
        end else if (cnt_inc > cap_reg) begin
            cmd.op       = kvrp_pkg::OP_CAP;
            stopped_next = 1'b1;
        end else begin
            count_next = cnt_inc;
            if (in_byte == kvrp_pkg::ChNl) begin
                cmd.op       = kvrp_pkg::OP_LINE;
                held_cr_next = 1'b0;
                prev_nl_next = 1'b1;
            end else begin
                prev_nl_next  = 1'b0;
                cmd.op        = kvrp_pkg::OP_CONTENT;
                cmd.cr_first  = held_cr_reg;
                cmd.emit_byte = (in_byte != kvrp_pkg::ChCr);
                held_cr_next  = (in_byte == kvrp_pkg::ChCr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= kvrp_pkg::CapReset;
            count_reg   <= '0;
            prev_nl_reg <= 1'b0;
            held_cr_reg <= 1'b0;
            stopped_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (fire && !stopped_reg) begin
                count_reg   <= count_next;
                prev_nl_reg <= prev_nl_next;
                held_cr_reg <= held_cr_next;
                stopped_reg <= stopped_next;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/kvrp_queue.sv */
`default_nettype none
module kvrp_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            wr_valid,
    output logic                 wr_ready,
    input  wire kvrp_pkg::cmd_t  wr_data,
    output logic                 rd_valid,
    input  wire logic            rd_ready,
    output kvrp_pkg::cmd_t       rd_data
);

    kvrp_pkg::cmd_t mem_reg [kvrp_pkg::QDepth];
    logic [kvrp_pkg::QPtrW-1:0] wp_reg, rp_reg;
    logic [kvrp_pkg::QPtrW:0]   fill_reg;
    logic                       push, pop;

    assign wr_ready = (fill_reg != kvrp_pkg::QPtrW'(0) + (kvrp_pkg::QPtrW+1)'(kvrp_pkg::QDepth));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            fill_reg <= fill_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= (kvrp_pkg::QPtrW+1)'(kvrp_pkg::QDepth))
        else $error("queue overfilled");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wp_reg - rp_reg) == fill_reg[kvrp_pkg::QPtrW-1:0])
        else $error("queue pointers disagree with fill");
    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("queue fill did not grow");
`endif

endmodule
`default_nettype wire

/* rtl/kvrp_back.sv */
`default_nettype none
module kvrp_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cmd_valid,
    output logic                 cmd_ready,
    input  wire kvrp_pkg::cmd_t  cmd,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [79:0]          m_tdata,
    output logic                 m_tlast
);

    // Line state.
    logic        in_val_reg, has_cont_reg;
    logic [2:0]  mpos_reg;
    logic [1:0]  mflags_reg;
    logic [63:0] acc_reg;
    logic [4:0]  digits_reg;
    logic [1:0]  lerr_reg;
    // Record state.
    logic [2:0]  perr_reg;
    logic [63:0] saved_reg;
    logic        have_reg;
    // After a failed record every command is consumed without a result.
    logic        stop_reg;

    // A non-CR byte with a released CR gives two results; phase_reg marks the second.
    logic        phase_reg;

    logic [79:0] out_data_reg;
    logic        out_last_reg, out_valid_reg;

    logic        step;           // a command is processed this cycle (a result only if emit)
    logic        done;           // command fully handled
    logic        is_cr_phase;
    logic [7:0]  c;
    logic        out_free;
    logic [1:0]  kcls;

    // Next values.
    logic        in_val_next, has_cont_next;
    logic [2:0]  mpos_next;
    logic [1:0]  mflags_next;
    logic [63:0] acc_next;
    logic [4:0]  digits_next;
    logic [1:0]  lerr_next;
    logic [2:0]  perr_next;
    logic [63:0] saved_next;
    logic        have_next;
    logic        emit;
    logic        last_res;
    logic [2:0]  tok;
    logic [7:0]  ob;
    logic [1:0]  ocls;
    logic [2:0]  ost;
    logic [63:0] oid;
    logic [3:0]  dig;
    logic [67:0] acc10;
    logic [2:0]  st_rec;

    assign out_free    = !out_valid_reg || m_tready;
    assign is_cr_phase = cmd.cr_first && !phase_reg;
    assign c           = is_cr_phase ? kvrp_pkg::ChCr : cmd.data;
    assign step        = cmd_valid && out_free;
    assign done        = step && (stop_reg ||
                         !(is_cr_phase && cmd.emit_byte && cmd.op == kvrp_pkg::OP_CONTENT));
    assign cmd_ready   = done;

    always_comb begin
        if (mflags_reg[0] && mpos_reg == 3'd6)      kcls = kvrp_pkg::CLS_REQ;
        else if (mflags_reg[1] && mpos_reg == 3'd4) kcls = kvrp_pkg::CLS_TYPE;
        else                                       kcls = kvrp_pkg::CLS_OTHER;
    end

    assign dig   = 4'(c - kvrp_pkg::ChZero);
    assign acc10 = {4'd0, acc_reg} * 68'd10 + {64'd0, dig};

    always_comb begin
        in_val_next   = in_val_reg;
        has_cont_next = has_cont_reg;
        mpos_next     = mpos_reg;
        mflags_next   = mflags_reg;
        acc_next      = acc_reg;
        digits_next   = digits_reg;
        lerr_next     = lerr_reg;
        perr_next     = perr_reg;
        saved_next    = saved_reg;
        have_next     = have_reg;
        emit = 1'b0;
        tok  = kvrp_pkg::TOK_KEY;
        ob   = '0;
        ocls = '0;
        ost  = '0;
        oid  = '0;
        st_rec = perr_reg;
        if (perr_reg == kvrp_pkg::ST_OK && !have_reg) st_rec = kvrp_pkg::ST_MISSING;
        unique case (cmd.op)
            kvrp_pkg::OP_CONTENT: begin
                if (is_cr_phase || cmd.emit_byte) begin
                    emit = 1'b1;
                    has_cont_next = 1'b1;
                    if (in_val_reg) begin
                        tok = kvrp_pkg::TOK_VAL;
                        ob  = c;
                        if (kcls == kvrp_pkg::CLS_REQ) begin
                            if (digits_reg <= kvrp_pkg::MaxIdDigits)
                                digits_next = digits_reg + 5'd1;
                            if (lerr_reg == 2'd0) begin
                                if (c < kvrp_pkg::ChZero || c > kvrp_pkg::ChNine)
                                    lerr_next = 2'd1;
                                else if (acc10[67:64] != 4'd0)
                                    lerr_next = 2'd2;
                                else
                                    acc_next = acc10[63:0];
                            end
                        end
                    end else if (c == kvrp_pkg::ChEq) begin
                        in_val_next = 1'b1;
                        tok  = kvrp_pkg::TOK_KEYEND;
                        ocls = kcls;
                    end else begin
                        if (!(mpos_reg < 3'd6 && kvrp_pkg::req_char(mpos_reg) == c))
                            mflags_next[0] = 1'b0;
                        if (!(mpos_reg < 3'd4 && kvrp_pkg::type_char(mpos_reg) == c))
                            mflags_next[1] = 1'b0;
                        if (mpos_reg < 3'd7) mpos_next = mpos_reg + 3'd1;
                        tok = kvrp_pkg::TOK_KEY;
                        ob  = c;
                    end
                end
            end
            kvrp_pkg::OP_LINE: begin
                if (has_cont_reg) begin
                    emit = 1'b1;
                    tok  = kvrp_pkg::TOK_LINE;
                    if (perr_reg == kvrp_pkg::ST_OK) begin
                        if (!in_val_reg) begin
                            perr_next = kvrp_pkg::ST_NO_EQ;
                        end else if (kcls == kvrp_pkg::CLS_REQ) begin
                            if (digits_reg == 5'd0 || digits_reg > kvrp_pkg::MaxIdDigits)
                                perr_next = kvrp_pkg::ST_BAD_ID;
                            else if (lerr_reg != 2'd0)
                                perr_next = {1'b0, lerr_reg} + 3'd1;
                            else begin
                                saved_next = acc_reg;
                                have_next  = 1'b1;
                            end
                        end
                    end
                end
                in_val_next = 1'b0; has_cont_next = 1'b0; mpos_next = '0;
                mflags_next = 2'b11; acc_next = '0; digits_next = '0; lerr_next = '0;
            end
            kvrp_pkg::OP_TERM: begin
                emit = 1'b1;
                tok  = kvrp_pkg::TOK_REC;
                ost  = st_rec;
                oid  = saved_reg;
                in_val_next = 1'b0; has_cont_next = 1'b0; mpos_next = '0;
                mflags_next = 2'b11; acc_next = '0; digits_next = '0; lerr_next = '0;
                perr_next = '0; saved_next = '0; have_next = 1'b0;
            end
            kvrp_pkg::OP_CAP: begin
                emit = 1'b1;
                tok  = kvrp_pkg::TOK_REC;
                ost  = kvrp_pkg::ST_OVER_CAP;
                oid  = saved_reg;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        if (stop_reg) emit = 1'b0;
        last_res = !(is_cr_phase && cmd.emit_byte && cmd.op == kvrp_pkg::OP_CONTENT);
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            out_data_reg <= {oid, ost, ocls, ob, tok};
            out_last_reg <= last_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            stop_reg      <= 1'b0;
            in_val_reg    <= 1'b0;
            has_cont_reg  <= 1'b0;
            mpos_reg      <= '0;
            mflags_reg    <= 2'b11;
            acc_reg       <= '0;
            digits_reg    <= '0;
            lerr_reg      <= '0;
            perr_reg      <= '0;
            saved_reg     <= '0;
            have_reg      <= 1'b0;
        end else begin
            if (out_free) out_valid_reg <= step && emit;
            if (step && (cmd.op == kvrp_pkg::OP_CAP ||
                         (cmd.op == kvrp_pkg::OP_TERM && st_rec != kvrp_pkg::ST_OK))) begin
                stop_reg <= 1'b1;
            end
            if (step) begin
                phase_reg    <= !done;
                in_val_reg   <= in_val_next;
                has_cont_reg <= has_cont_next;
                mpos_reg     <= mpos_next;
                mflags_reg   <= mflags_next;
                acc_reg      <= acc_next;
                digits_reg   <= digits_next;
                lerr_reg     <= lerr_next;
                perr_reg     <= perr_next;
                saved_reg    <= saved_next;
                have_reg     <= have_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_phase_only_cr: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> cmd_valid && cmd.cr_first)
        else $error("second phase without released CR");
    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step && emit && !done |=> !m_tlast)
        else $error("released CR marked last");
`endif

endmodule
`default_nettype wire

/* rtl/key_value_record_parser_unit.sv */
// Path: a byte's first result goes through the command queue and the output register;
// a second result, for a byte that releases a held CR, follows it from the same register.
// Throughput: one byte per cycle while the queue has room; a CR release costs the back end
// an extra step, which the 4-entry queue absorbs in bursts.
// Result-side stalls also hold the flow back. Reset: aresetn, synchronous active low,
// clears all parser state, sets the cap register to 65536 and clears the stop flags.
`default_nettype none
module key_value_record_parser_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [20:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // token, out_byte, key_class, status, request_id
    output logic             m_tlast    // last
);

    logic           f_valid, f_ready, q_valid, q_ready;
    kvrp_pkg::cmd_t f_cmd, q_cmd;

    kvrp_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    kvrp_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );

    kvrp_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

endmodule
`default_nettype wire

/* tb/sv/kvrp_checker.sv */
`default_nettype none
module kvrp_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [20:0] cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [79:0] m_tdata,   // token, out_byte, key_class, status, request_id
    input  wire logic        m_tlast,   // last
    output int               fail_count,
    output int               pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        kvrp_pkg::token_t     tok;
        logic [7:0]           data;
        kvrp_pkg::key_class_t cls;
        kvrp_pkg::status_t    st;
        logic [63:0]          id;
        logic                 last;
    } token_item_t;

    token_item_t token_q[$];

    // Mirror of the parser state.
    logic        nl_seen, cr_held, in_value, has_content, id_seen, halted;
    logic [2:0]  kpos;
    logic [1:0]  kflags;
    logic [20:0] rec_count, cap;
    kvrp_pkg::status_t first_err;
    logic [63:0] id_acc, id_saved;
    logic [4:0]  digits;
    logic [1:0]  line_err;

    string req_name = "req_id";
    string type_name = "type";

    function automatic kvrp_pkg::key_class_t current_class();
        if (kflags[0] && kpos == 3'd6) return kvrp_pkg::CLS_REQ;
        if (kflags[1] && kpos == 3'd4) return kvrp_pkg::CLS_TYPE;
        return kvrp_pkg::CLS_OTHER;
    endfunction

    task automatic push_token(kvrp_pkg::token_t tok, logic [7:0] d, kvrp_pkg::key_class_t c,
                              kvrp_pkg::status_t s, logic [63:0] id);
        token_item_t t;
        t.tok = tok; t.data = d; t.cls = c; t.st = s; t.id = id; t.last = 1'b0;
        token_q.insert(token_q.size(), t);
    endtask

    task automatic clear_line();
        in_value = 0; has_content = 0; kpos = 0; kflags = 2'b11;
        id_acc = 0; digits = 0; line_err = 0;
    endtask

    task automatic clear_record();
        clear_line();
        nl_seen = 0; cr_held = 0; rec_count = 0; first_err = kvrp_pkg::ST_OK;
        id_saved = 0; id_seen = 0;
    endtask

    task automatic take_content(logic [7:0] c);
        logic [63:0] d;
        has_content = 1;
        if (in_value) begin
            push_token(kvrp_pkg::TOK_VAL, c, kvrp_pkg::CLS_OTHER, kvrp_pkg::ST_OK, 64'd0);
            if (current_class() == kvrp_pkg::CLS_REQ) begin
                if (digits <= 5'd20) digits++;
                if (line_err == 0) begin
                    if (c < 8'h30 || c > 8'h39) begin
                        line_err = 1;
                    end else begin
                        d = 64'(c - 8'h30);
                        if (id_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) line_err = 2;
                        else id_acc = id_acc * 10 + d;
                    end
                end
            end
        end else if (c == 8'h3D) begin
            in_value = 1;
            push_token(kvrp_pkg::TOK_KEYEND, 8'd0, current_class(), kvrp_pkg::ST_OK, 64'd0);
        end else begin
            if (!(kpos < 6 && req_name[kpos] == c)) kflags[0] = 0;
            if (!(kpos < 4 && type_name[kpos] == c)) kflags[1] = 0;
            if (kpos < 7) kpos++;
            push_token(kvrp_pkg::TOK_KEY, c, kvrp_pkg::CLS_OTHER, kvrp_pkg::ST_OK, 64'd0);
        end
    endtask

    task automatic close_line();
        if (first_err != kvrp_pkg::ST_OK) return;
        if (!in_value) begin
            first_err = kvrp_pkg::ST_NO_EQ;
        end else if (current_class() == kvrp_pkg::CLS_REQ) begin
            if (digits == 0 || digits > 5'd20) first_err = kvrp_pkg::ST_BAD_ID;
            else if (line_err == 1) first_err = kvrp_pkg::ST_BAD_ID;
            else if (line_err == 2) first_err = kvrp_pkg::ST_OVERFLOW;
            else begin
                id_saved = id_acc;
                id_seen = 1;
            end
        end
    endtask

    task automatic predict_byte(logic [7:0] b);
        int n0;
        kvrp_pkg::status_t s;
        logic [20:0] cnt;
        n0 = token_q.size();
        if (halted) return;
        if (b == 8'h0A && nl_seen) begin
            s = first_err;
            if (s == kvrp_pkg::ST_OK && !id_seen) s = kvrp_pkg::ST_MISSING;
            push_token(kvrp_pkg::TOK_REC, 8'd0, kvrp_pkg::CLS_OTHER, s, id_saved);
            if (s != kvrp_pkg::ST_OK) halted = 1;
            clear_record();
        end else begin
            cnt = (rec_count != 21'h1FFFFF) ? rec_count + 21'd1 : rec_count;
            if (cnt > cap) begin
                push_token(kvrp_pkg::TOK_REC, 8'd0, kvrp_pkg::CLS_OTHER,
                           kvrp_pkg::ST_OVER_CAP, id_saved);
                halted = 1;
            end else begin
                rec_count = cnt;
                if (b == 8'h0A) begin
                    cr_held = 0;
                    if (has_content) begin
                        push_token(kvrp_pkg::TOK_LINE, 8'd0, kvrp_pkg::CLS_OTHER,
                                   kvrp_pkg::ST_OK, 64'd0);
                        close_line();
                    end
                    clear_line();
                    nl_seen = 1;
                end else begin
                    nl_seen = 0;
                    if (cr_held) begin
                        cr_held = 0;
                        take_content(8'h0D);
                    end
                    if (b == 8'h0D) cr_held = 1;
                    else take_content(b);
                end
            end
        end
        if (token_q.size() > n0) token_q[token_q.size()-1].last = 1'b1;
    endtask

    task automatic compare_token();
        token_item_t e;
        logic [79:0] want;
        if (token_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result item: tdata=%h tlast=%b", m_tdata, m_tlast);
            return;
        end
        e = token_q.pop_front();
        want = {e.id, e.st, e.cls, e.data, e.tok};
        if (m_tdata !== want || m_tlast !== e.last) begin
            fail_count++;
            if (fail_count <= 10)
                $display("result mismatch: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                         want, e.last, m_tdata, m_tlast);
        end
    endtask

    initial begin
        fail_count = 0;
        pending_results = 0;
        cap = kvrp_pkg::CapReset;
        halted = 0;
        clear_record();
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            token_q.delete();
            cap = kvrp_pkg::CapReset;
            halted = 0;
            clear_record();
        end else begin
            if (m_tvalid && m_tready) compare_token();
            if (cfg_valid && cfg_ready) cap = cfg_data;
            if (s_tvalid && s_tready) predict_byte(s_tdata);
        end
        pending_results = token_q.size();
    end
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 600000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [20:0] cfg_data = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;
    logic        m_tlast;
    int          fail_count, pending_results;

    logic s_fire = 0, cfg_fire = 0;
    int   cycles = 0;
    int   sent = 0;
    int   stall_left = 0;
    logic [7:0] text_q[$];

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    key_value_record_parser_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    kvrp_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    always @(posedge aclk) begin
        s_fire <= s_tvalid && s_tready;
        cfg_fire <= cfg_valid && cfg_ready;
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    // Result side back-pressure, with the same mix of short and long stalls.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    task automatic add_byte(logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    function automatic logic [7:0] free_byte(logic no_eq);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == 8'h0A || (no_eq && b == 8'h3D));
        return b;
    endfunction

    task automatic add_line_end();
        if ($urandom_range(0, 3) == 0) add_byte(8'h0D);
        add_byte(8'h0A);
        // An empty CR line does not end the record.
        if ($urandom_range(0, 7) == 0) add_text("\r\n");
    endtask

    task automatic add_good_record();
        int lines, id_line, nd;
        string keys[6] = '{"type", "req_i", "req_idx", "typ", "types", "t"};
        if ($urandom_range(0, 5) == 0) add_text("\n");
        lines = $urandom_range(1, 4);
        id_line = $urandom_range(0, lines - 1);
        for (int l = 0; l < lines; l++) begin
            if (l == id_line) begin
                add_text("req_id=");
                nd = ($urandom_range(0, 7) == 0) ? 20 : $urandom_range(1, 19);
                for (int i = 0; i < nd; i++)
                    add_byte((nd == 20 && i == 0) ? 8'h31 : 8'(8'h30 + $urandom_range(0, 9)));
            end else begin
                if ($urandom_range(0, 1) == 0) add_text(keys[$urandom_range(0, 5)]);
                else repeat ($urandom_range(1, 8)) add_byte(free_byte(1));
                add_byte(8'h3D);
                repeat ($urandom_range(0, 20)) add_byte(free_byte(0));
            end
            add_line_end();
        end
        add_byte(8'h0A);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_text();
        int g;
        while (text_q.size() > 0) begin
            g = pick_gap();
            if (g > 0) begin
                s_tvalid <= 0;
                repeat (g) @(negedge aclk);
            end
            s_tvalid <= 1;
            s_tdata <= text_q.pop_front();
            do @(negedge aclk); while (!s_fire);
            sent++;
        end
        s_tvalid <= 0;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending_results != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_cap(logic [20:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data <= v;
        do @(negedge aclk); while (!cfg_fire);
        cfg_valid <= 0;
    endtask

    initial begin
        int kind;
        logic [20:0] caps[4] = '{21'd1048576, 21'd200, 21'd1000, 21'd65536};
        repeat (2) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed records at the reset cap.
        add_text("type=x\r\nreq_id=18446744073709551615\r\n\r\n\n");
        add_text("\na\rb=c\r\r\nreq_id=0\n\xff\x80=\x00\x7f\nreq_id=00042\n\n");
        add_text("req_i=z\nreq_idx=5\ntypes=\ntyp=q\ntype=\nreq_id=3\n\n");
        send_text();
        // A record exactly at the cap.
        write_cap(21'd9);
        add_text("req_id=1\n\n");
        send_text();

        for (int ph = 0; sent < 1400; ph++) begin
            write_cap(caps[ph % 4]);
            for (int i = 0; i < 4; i++) add_good_record();
            send_text();
            if (ph == 1) drain();
        end

        // One failing record ends the stream; the block then ignores the rest.
        drain();
        kind = $urandom_range(1, 5);
        case (kind)
            1: add_text("req_id=7\nnoequals\n\n");
            2: case ($urandom_range(0, 2))
                   0: add_text("req_id=12a\n\n");
                   1: add_text("req_id=\n\n");
                   default: add_text("req_id=111111111111111111111\n\n");
               endcase
            3: add_text("req_id=18446744073709551616\nreq_id=5\n\n");
            4: if ($urandom_range(0, 1) == 0) add_text("type=a\n\n"); else add_text("\n\n");
            default: begin
                add_text("req_id=12\n");
                write_cap(21'($urandom_range(1, 12)));
                add_text("type=abcdefghijklmnop\n\n");
            end
        endcase
        repeat (20) add_byte(8'($urandom_range(0, 255)));
        send_text();

        while (pending_results != 0 && cycles < CycleLimit) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
